// ===== rtl/core/bicubic_bezier_patch_eval_defines.svh =====
// Assertion macros used by the checker file of the Bezier patch evaluator.
`ifndef BICUBIC_BEZIER_PATCH_EVAL_DEFINES_SVH
`define BICUBIC_BEZIER_PATCH_EVAL_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbp_checker: property failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define BBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbp_checker: property failed");

`endif

// ===== rtl/core/bbp_pkg.sv =====
// Shared types and constants of the Bezier patch evaluator.
`timescale 1ns / 1ps
`default_nettype none

package bbp_pkg;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WGT,
        OP_ROW,
        OP_VBL
    } op_kind_t;

    typedef enum logic [2:0] {
        WOP_AA,
        WOP_TT,
        WOP_A2A,
        WOP_A2T,
        WOP_AT2,
        WOP_T2T
    } wop_t;

    typedef struct packed {
        op_kind_t   kind;
        logic       psel;
        wop_t       wop;
        logic [1:0] coord;
        logic [1:0] row;
        logic [1:0] k;
    } tag_t;

    localparam int POINTS         = 16;
    localparam int POINT_IDX_BITS = 4;
    localparam int CNT_BITS       = 7;

    localparam logic [CNT_BITS-1:0] WOPS_PER_PARAM = 7'd6;
    localparam logic [CNT_BITS-1:0] WGT_END        = 7'd12;
    localparam logic [CNT_BITS-1:0] ROW_END        = 7'd60;
    localparam logic [CNT_BITS-1:0] LAST_ISSUE     = 7'd71;

    localparam logic [1:0] K_FIRST = 2'd0;
    localparam logic [1:0] K_LAST  = 2'd3;
    localparam logic [1:0] COORD_X = 2'd0;
    localparam logic [1:0] COORD_Y = 2'd1;
    localparam logic [1:0] COORD_Z = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/bicubic_bezier_patch_eval.sv =====
// Top level of the bicubic Bezier patch evaluator: sequencer, operand routing and results.
// A load transaction writes one control point at its accept edge and leaves busy low.
// An evaluate transaction raises busy and ends with done.
// Issue slots 0 to 71 feed the one shared multiplier, and the last passes 4 register stages.
// busy falls as done rises and the done cycle may accept a new transaction.
// Reset clears all control points to zero, busy and done low; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module bicubic_bezier_patch_eval #(
    parameter int COORD_BITS      = 32,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic [3:0]                   point_index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic [PARAM_FRAC_BITS:0]     param_u,
    input  logic [PARAM_FRAC_BITS:0]     param_v,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] surf_x,
    output logic signed [COORD_BITS-1:0] surf_y,
    output logic signed [COORD_BITS-1:0] surf_z
);

    localparam int PB = PARAM_FRAC_BITS + 1;
    localparam int MA = (COORD_BITS > PARAM_FRAC_BITS + 2) ? COORD_BITS : PARAM_FRAC_BITS + 2;
    localparam int PW = MA + PB + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [bbp_pkg::CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic signed [COORD_BITS-1:0]    surf_x_reg, surf_x_next;
    logic signed [COORD_BITS-1:0]    surf_y_reg, surf_y_next;
    logic signed [COORD_BITS-1:0]    surf_z_reg, surf_z_next;

    bbp_pkg::tag_t                   issue_tag;
    bbp_pkg::tag_t                   tag_s1_reg;
    bbp_pkg::tag_t                   tag_s2_reg;
    bbp_pkg::tag_t                   tag_s3_reg;

    logic [bbp_pkg::CNT_BITS-1:0]    j_row;
    logic [bbp_pkg::CNT_BITS-1:0]    j_vbl;
    logic [bbp_pkg::CNT_BITS-1:0]    j_wop;

    logic                            accept;
    logic                            load_we;
    logic                            eval_go;
    logic                            final_wr;

    logic signed [COORD_BITS-1:0]    rd_x, rd_y, rd_z;
    logic signed [COORD_BITS-1:0]    coord_sel;
    logic signed [COORD_BITS-1:0]    rows_reg [12];
    logic signed [COORD_BITS-1:0]    res_x_reg, res_y_reg;

    logic [PB-1:0]                   wgt_op_a, wgt_op_b, blend_w;
    logic signed [MA-1:0]            mul_a;
    logic [PB-1:0]                   mul_b;
    logic signed [PW-1:0]            prod;
    logic signed [COORD_BITS-1:0]    sat;
    logic                            acc_en;

    assign accept  = start & ~busy_reg;
    assign load_we = accept & ~mode;
    assign eval_go = accept & mode;

    assign j_row = cnt_reg - bbp_pkg::WGT_END;
    assign j_vbl = cnt_reg - bbp_pkg::ROW_END;
    assign j_wop = cnt_reg - bbp_pkg::WOPS_PER_PARAM;

    // Issue order: weight products for u then v, the row blends of x, y and z,
    // then the column blends of x, y and z.
    always_comb
    begin
        issue_tag = '0;
        if (state_reg == ST_ISSUE)
        begin
            priority if (cnt_reg < bbp_pkg::WOPS_PER_PARAM)
            begin
                issue_tag.kind = bbp_pkg::OP_WGT;
                issue_tag.psel = 1'b0;
                issue_tag.wop  = bbp_pkg::wop_t'(cnt_reg[2:0]);
            end
            else if (cnt_reg < bbp_pkg::WGT_END)
            begin
                issue_tag.kind = bbp_pkg::OP_WGT;
                issue_tag.psel = 1'b1;
                issue_tag.wop  = bbp_pkg::wop_t'(j_wop[2:0]);
            end
            else if (cnt_reg < bbp_pkg::ROW_END)
            begin
                issue_tag.kind  = bbp_pkg::OP_ROW;
                issue_tag.coord = j_row[5:4];
                issue_tag.row   = j_row[3:2];
                issue_tag.k     = j_row[1:0];
            end
            else
            begin
                issue_tag.kind  = bbp_pkg::OP_VBL;
                issue_tag.coord = j_vbl[3:2];
                issue_tag.k     = j_vbl[1:0];
            end
        end
    end

    assign final_wr = (tag_s3_reg.kind == bbp_pkg::OP_VBL) &&
                      (tag_s3_reg.k == bbp_pkg::K_LAST) &&
                      (tag_s3_reg.coord == bbp_pkg::COORD_Z);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        surf_x_next = surf_x_reg;
        surf_y_next = surf_y_reg;
        surf_z_next = surf_z_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (eval_go)
                begin
                    state_next = ST_ISSUE;
                    cnt_next   = '0;
                    busy_next  = 1'b1;
                end
            end
            ST_ISSUE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == bbp_pkg::LAST_ISSUE)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (final_wr)
                begin
                    state_next  = ST_IDLE;
                    busy_next   = 1'b0;
                    done_next   = 1'b1;
                    surf_x_next = res_x_reg;
                    surf_y_next = res_y_reg;
                    surf_z_next = sat;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            surf_x_reg <= '0;
            surf_y_reg <= '0;
            surf_z_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            surf_x_reg <= surf_x_next;
            surf_y_reg <= surf_y_next;
            surf_z_reg <= surf_z_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s1_reg <= '0;
            tag_s2_reg <= '0;
            tag_s3_reg <= '0;
        end
        else
        begin
            tag_s1_reg <= issue_tag;
            tag_s2_reg <= tag_s1_reg;
            tag_s3_reg <= tag_s2_reg;
        end
    end

    bbp_store #(
        .COORD_BITS (COORD_BITS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (load_we),
        .waddr (point_index),
        .wx    (coord_x),
        .wy    (coord_y),
        .wz    (coord_z),
        .raddr ({issue_tag.row, issue_tag.k}),
        .rd_x  (rd_x),
        .rd_y  (rd_y),
        .rd_z  (rd_z)
    );

    bbp_weights #(
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_weights (
        .clk     (clk),
        .load    (eval_go),
        .param_u (param_u),
        .param_v (param_v),
        .rd_psel (tag_s1_reg.psel),
        .rd_wop  (tag_s1_reg.wop),
        .op_a    (wgt_op_a),
        .op_b    (wgt_op_b),
        .bl_psel (tag_s1_reg.kind == bbp_pkg::OP_VBL),
        .bl_k    (tag_s1_reg.k),
        .bl_w    (blend_w),
        .wr_en   (tag_s2_reg.kind == bbp_pkg::OP_WGT),
        .wr_psel (tag_s2_reg.psel),
        .wr_wop  (tag_s2_reg.wop),
        .prod_lo (prod[2*PARAM_FRAC_BITS:0])
    );

    always_comb
    begin
        unique case (tag_s1_reg.coord)
            bbp_pkg::COORD_X: coord_sel = rd_x;
            bbp_pkg::COORD_Y: coord_sel = rd_y;
            default:          coord_sel = rd_z;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (tag_s1_reg.kind)
            bbp_pkg::OP_WGT:
            begin
                mul_a = MA'(wgt_op_a);
                mul_b = wgt_op_b;
            end
            bbp_pkg::OP_ROW:
            begin
                mul_a = MA'(coord_sel);
                mul_b = blend_w;
            end
            bbp_pkg::OP_VBL:
            begin
                mul_a = MA'(rows_reg[{tag_s1_reg.coord, tag_s1_reg.k}]);
                mul_b = blend_w;
            end
            default:
            begin
            end
        endcase
    end

    bbp_mul #(
        .A_BITS (MA),
        .B_BITS (PB)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign acc_en = (tag_s2_reg.kind == bbp_pkg::OP_ROW) ||
                    (tag_s2_reg.kind == bbp_pkg::OP_VBL);

    bbp_accum #(
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
        .PROD_BITS       (PW)
    ) u_accum (
        .clk   (clk),
        .en    (acc_en),
        .first (tag_s2_reg.k == bbp_pkg::K_FIRST),
        .prod  (prod),
        .sat   (sat)
    );

    always_ff @(posedge clk)
    begin
        if (tag_s3_reg.k == bbp_pkg::K_LAST)
        begin
            if (tag_s3_reg.kind == bbp_pkg::OP_ROW)
            begin
                rows_reg[{tag_s3_reg.coord, tag_s3_reg.row}] <= sat;
            end
            if (tag_s3_reg.kind == bbp_pkg::OP_VBL)
            begin
                if (tag_s3_reg.coord == bbp_pkg::COORD_X)
                begin
                    res_x_reg <= sat;
                end
                if (tag_s3_reg.coord == bbp_pkg::COORD_Y)
                begin
                    res_y_reg <= sat;
                end
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign surf_x = surf_x_reg;
    assign surf_y = surf_y_reg;
    assign surf_z = surf_z_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bbp_mul.sv =====
// Shared registered multiplier: signed operand times unsigned operand.
`timescale 1ns / 1ps
`default_nettype none

module bbp_mul #(
    parameter int A_BITS = 32,
    parameter int B_BITS = 17
) (
    input  logic                       clk,
    input  logic signed [A_BITS-1:0]   a,
    input  logic        [B_BITS-1:0]   b,
    output logic signed [A_BITS+B_BITS:0] prod
);

    logic signed [A_BITS+B_BITS:0] prod_reg;
    logic signed [A_BITS+B_BITS:0] prod_next;

    assign prod_next = a * signed'({1'b0, b});

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bbp_store.sv =====
// Control point store: 16 rows of x, y and z with per-row valid bits.
`timescale 1ns / 1ps
`default_nettype none

module bbp_store #(
    parameter int COORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  we,
    input  logic        [bbp_pkg::POINT_IDX_BITS-1:0] waddr,
    input  logic signed [COORD_BITS-1:0]          wx,
    input  logic signed [COORD_BITS-1:0]          wy,
    input  logic signed [COORD_BITS-1:0]          wz,
    input  logic        [bbp_pkg::POINT_IDX_BITS-1:0] raddr,
    output logic signed [COORD_BITS-1:0]          rd_x,
    output logic signed [COORD_BITS-1:0]          rd_y,
    output logic signed [COORD_BITS-1:0]          rd_z
);

    localparam int ROW_BITS = 3 * COORD_BITS;

    logic [ROW_BITS-1:0]            mem [bbp_pkg::POINTS];
    logic [bbp_pkg::POINTS-1:0]     valid_reg;
    logic [ROW_BITS-1:0]            rd_data_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wx, wy, wz};
        end
        rd_data_reg <= mem[raddr];
    end

    // A row never written reads as zero, which is its reset value.
    assign rd_x = rd_valid_reg ? signed'(rd_data_reg[3*COORD_BITS-1:2*COORD_BITS]) : '0;
    assign rd_y = rd_valid_reg ? signed'(rd_data_reg[2*COORD_BITS-1:COORD_BITS]) : '0;
    assign rd_z = rd_valid_reg ? signed'(rd_data_reg[COORD_BITS-1:0]) : '0;

endmodule

`default_nettype wire

// ===== rtl/core/bbp_weights.sv =====
// Bernstein weight registers, weight operand selection and weight write-back.
`timescale 1ns / 1ps
`default_nettype none

module bbp_weights #(
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic [PARAM_FRAC_BITS:0]      param_u,
    input  logic [PARAM_FRAC_BITS:0]      param_v,
    input  logic                          rd_psel,
    input  bbp_pkg::wop_t                 rd_wop,
    output logic [PARAM_FRAC_BITS:0]      op_a,
    output logic [PARAM_FRAC_BITS:0]      op_b,
    input  logic                          bl_psel,
    input  logic [1:0]                    bl_k,
    output logic [PARAM_FRAC_BITS:0]      bl_w,
    input  logic                          wr_en,
    input  logic                          wr_psel,
    input  bbp_pkg::wop_t                 wr_wop,
    input  logic [2*PARAM_FRAC_BITS:0]    prod_lo
);

    localparam int PB = PARAM_FRAC_BITS + 1;
    localparam int SB = 2 * PARAM_FRAC_BITS + 2;
    localparam logic [PB-1:0] ONE      = PB'(1) << PARAM_FRAC_BITS;
    localparam logic [SB-1:0] RND_HALF = SB'(1) << (PARAM_FRAC_BITS - 1);

    logic [PB-1:0] t_reg  [2];
    logic [PB-1:0] a_reg  [2];
    logic [PB-1:0] a2_reg [2];
    logic [PB-1:0] t2_reg [2];
    logic [PB-1:0] w_reg  [2][4];

    logic [PB-1:0] tu;
    logic [PB-1:0] tv;
    logic [SB-1:0] rnd_sum;
    logic [PB-1:0] rnd_q;
    logic [PB+1:0] rnd3_wide;
    logic [PB-1:0] rnd3;

    assign tu = (param_u > ONE) ? ONE : param_u;
    assign tv = (param_v > ONE) ? ONE : param_v;

    assign rnd_sum   = {1'b0, prod_lo} + RND_HALF;
    assign rnd_q     = rnd_sum[2*PARAM_FRAC_BITS:PARAM_FRAC_BITS];
    assign rnd3_wide = ({2'b00, rnd_q} << 1) + {2'b00, rnd_q};
    assign rnd3      = rnd3_wide[PB-1:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            t_reg[0] <= tu;
            a_reg[0] <= ONE - tu;
            t_reg[1] <= tv;
            a_reg[1] <= ONE - tv;
        end
        if (wr_en)
        begin
            unique case (wr_wop)
                bbp_pkg::WOP_AA:  a2_reg[wr_psel]   <= rnd_q;
                bbp_pkg::WOP_TT:  t2_reg[wr_psel]   <= rnd_q;
                bbp_pkg::WOP_A2A: w_reg[wr_psel][0] <= rnd_q;
                bbp_pkg::WOP_A2T: w_reg[wr_psel][1] <= rnd3;
                bbp_pkg::WOP_AT2: w_reg[wr_psel][2] <= rnd3;
                bbp_pkg::WOP_T2T: w_reg[wr_psel][3] <= rnd_q;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (rd_wop)
            bbp_pkg::WOP_AA:
            begin
                op_a = a_reg[rd_psel];
                op_b = a_reg[rd_psel];
            end
            bbp_pkg::WOP_TT:
            begin
                op_a = t_reg[rd_psel];
                op_b = t_reg[rd_psel];
            end
            bbp_pkg::WOP_A2A:
            begin
                op_a = a2_reg[rd_psel];
                op_b = a_reg[rd_psel];
            end
            bbp_pkg::WOP_A2T:
            begin
                op_a = a2_reg[rd_psel];
                op_b = t_reg[rd_psel];
            end
            bbp_pkg::WOP_AT2:
            begin
                op_a = a_reg[rd_psel];
                op_b = t2_reg[rd_psel];
            end
            bbp_pkg::WOP_T2T:
            begin
                op_a = t2_reg[rd_psel];
                op_b = t_reg[rd_psel];
            end
            default:
            begin
            end
        endcase
    end

    assign bl_w = w_reg[bl_psel][bl_k];

endmodule

`default_nettype wire

// ===== rtl/core/bbp_accum.sv =====
// Blend accumulator with rounding offset, floor shift and saturation.
`timescale 1ns / 1ps
`default_nettype none

module bbp_accum #(
    parameter int COORD_BITS      = 32,
    parameter int PARAM_FRAC_BITS = 16,
    parameter int PROD_BITS       = 51
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic                         first,
    input  logic signed [PROD_BITS-1:0]  prod,
    output logic signed [COORD_BITS-1:0] sat
);

    localparam int AW = COORD_BITS + PARAM_FRAC_BITS + 3;
    localparam int HB = AW - COORD_BITS + 1;
    localparam logic signed [AW-1:0] HALF = signed'(AW'(1) << (PARAM_FRAC_BITS - 1));
    localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] shifted;
    logic        [HB-1:0] hi_bits;
    logic                 fits;

    assign acc_next = (first ? HALF : acc_reg) + AW'(prod);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign shifted = acc_reg >>> PARAM_FRAC_BITS;
    assign hi_bits = shifted[AW-1:COORD_BITS-1];
    assign fits    = (&hi_bits) | ~(|hi_bits);
    assign sat     = fits ? signed'(shifted[COORD_BITS-1:0])
                          : signed'(acc_reg[AW-1] ? CMIN : CMAX);

endmodule

`default_nettype wire

// ===== rtl/core/bbp_checker.sv =====
// Port-level checker of the Bezier patch evaluator and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

`include "bicubic_bezier_patch_eval_defines.svh"

module bbp_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic mode,
    input wire logic done
);

    `BBP_ASSERT_NOW(a_done_not_busy, done, !busy)
    `BBP_ASSERT_NEXT(a_done_single, done, !done)
    `BBP_ASSERT_NEXT(a_eval_goes_busy, start && !busy && mode, busy)
    `BBP_ASSERT_NEXT(a_load_stays_free, start && !busy && !mode, !busy && !done)
    `BBP_ASSERT_NOW(a_busy_ends_with_done, $fell(busy), done)

endmodule

bind bicubic_bezier_patch_eval bbp_checker u_bbp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .mode  (mode),
    .done  (done)
);

`default_nettype wire
